FILE: rtl/core/trq_pkg.sv
package trq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned MAX_RESULTS     = 16;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned REF_W           = 16;
	localparam int unsigned QUANT_W         = 16;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_POLL = 2'd2;

	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_FULL     = 3'd1;
	localparam logic [2:0] KIND_TICKED   = 3'd2;
	localparam logic [2:0] KIND_RELEASED = 3'd3;
	localparam logic [2:0] KIND_NONE_DUE = 3'd4;
	localparam logic [2:0] KIND_MISSED   = 3'd5;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] start_time;
		logic [REF_W-1:0]  ref_index;
	} trq_req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [TIME_W-1:0] out_start_time;
		logic [REF_W-1:0]  out_ref_index;
		logic [TIME_W-1:0] now;
		logic              quantum_expired;
		logic              last;
	} trq_rsp_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

FILE: rtl/core/trq_ifs.sv
interface trq_req_if;
	logic              valid;
	logic              ready;
	trq_pkg::trq_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trq_rsp_if;
	logic              valid;
	logic              ready;
	trq_pkg::trq_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/timed_release_queue.sv
// Add, tick and poll transactions that give one result show it in the cycle after acceptance.
// A releasing poll gives one entry per cycle when not stalled, up to sixteen per poll.
// One input transaction is taken at a time; the next waits until the release run has ended.
// A write of the quantum register starts a remainder pass that holds off inputs until done.
// Reset clears the entry count and the time and sets the quantum to one; stored entries stay.
module timed_release_queue #(
	parameter int unsigned QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [trq_pkg::QUANT_W-1:0]   cfg_wdata,
	trq_req_if.sink                       req,
	trq_rsp_if.source                     rsp
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned REL_W = $clog2(trq_pkg::MAX_RESULTS);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_REL  = 1'b1;

	logic                          state_q;
	logic [CNT_W-1:0]              count_q;
	logic [REL_W-1:0]              rel_cnt_q;
	logic [trq_pkg::TIME_W-1:0]    time_q;
	logic [trq_pkg::QUANT_W-1:0]   quantum_q;
	logic [trq_pkg::QUANT_W-1:0]   phase_q;
	logic                          rsp_valid_q;
	trq_pkg::trq_rsp_t             rsp_q;

	logic                          rem_busy;
	logic                          rem_done;
	logic [trq_pkg::QUANT_W-1:0]   rem_res;

	logic                          rsp_free;
	logic                          accept;
	logic                          full;
	logic                          rel_fire;
	logic                          rel_last;
	logic                          load;
	trq_pkg::trq_rsp_t             rsp_d;
	trq_pkg::cell_ctrl_t           ctrl;
	logic [trq_pkg::QUANT_W:0]     phase_inc;
	logic                          time_max;

	logic [trq_pkg::TIME_W-1:0]    key_w [QUEUE_DEPTH];
	logic [trq_pkg::REF_W-1:0]     ref_w [QUEUE_DEPTH];
	logic                          gt_w  [QUEUE_DEPTH];
	logic                          occ_w [QUEUE_DEPTH];

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && rsp_free && !rem_busy && !rem_done;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rel_fire  = (state_q == ST_REL) && rsp_free;
	assign rel_last  = (rel_cnt_q == REL_W'(trq_pkg::MAX_RESULTS - 1)) ||
		(count_q == CNT_W'(1)) || (key_w[1] != time_q);
	assign phase_inc = {1'b0, phase_q} + 17'd1;
	assign time_max  = &time_q;

	assign ctrl.insert = accept && (req.data.mode == trq_pkg::MODE_ADD) && !full;
	assign ctrl.shift  = rel_fire;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			assign occ_w[gi] = (CNT_W'(gi) < count_q);
			trq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ_w[gi]),
				.new_key   (req.data.start_time),
				.new_ref   (req.data.ref_index),
				.left_gt   ((gi == 0) ? 1'b0 : gt_w[(gi == 0) ? 0 : gi - 1]),
				.left_key  (key_w[(gi == 0) ? 0 : gi - 1]),
				.left_ref  (ref_w[(gi == 0) ? 0 : gi - 1]),
				.right_key (key_w[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
				.right_ref (ref_w[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
				.gt        (gt_w[gi]),
				.key       (key_w[gi]),
				.ref_idx   (ref_w[gi])
			);
		end
	endgenerate

	trq_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_we),
		.dividend  (time_q),
		.divisor   (cfg_wdata),
		.busy      (rem_busy),
		.done      (rem_done),
		.remainder (rem_res)
	);

	always_comb begin
		rsp_d = '0;
		rsp_d.now = time_q;
		rsp_d.last = 1'b1;
		load = 1'b0;
		if (rel_fire) begin
			load = 1'b1;
			rsp_d.kind = trq_pkg::KIND_RELEASED;
			rsp_d.out_start_time = key_w[0];
			rsp_d.out_ref_index = ref_w[0];
			rsp_d.last = rel_last;
		end else if (accept) begin
			unique case (req.data.mode)
				trq_pkg::MODE_ADD: begin
					load = 1'b1;
					rsp_d.kind = full ? trq_pkg::KIND_FULL : trq_pkg::KIND_ADDED;
				end
				trq_pkg::MODE_TICK: begin
					load = 1'b1;
					rsp_d.kind = trq_pkg::KIND_TICKED;
					if (time_max) begin
						rsp_d.quantum_expired = (quantum_q != '0) && (phase_q == '0);
					end else begin
						rsp_d.now = time_q + 32'd1;
						rsp_d.quantum_expired = (quantum_q != '0) &&
							(phase_inc == {1'b0, quantum_q});
					end
				end
				trq_pkg::MODE_POLL: begin
					if (count_q == '0 || key_w[0] > time_q) begin
						load = 1'b1;
						rsp_d.kind = trq_pkg::KIND_NONE_DUE;
					end else if (key_w[0] < time_q) begin
						load = 1'b1;
						rsp_d.kind = trq_pkg::KIND_MISSED;
					end
				end
				default: begin
					load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rel_cnt_q   <= '0;
			time_q      <= '0;
			quantum_q   <= 16'd1;
			phase_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (rem_done) begin
				phase_q <= rem_res;
			end
			if (ctrl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (accept && req.data.mode == trq_pkg::MODE_TICK && !time_max) begin
				time_q <= time_q + 32'd1;
				if (phase_inc == {1'b0, quantum_q}) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_inc[trq_pkg::QUANT_W-1:0];
				end
			end
			if (accept && req.data.mode == trq_pkg::MODE_POLL && count_q != '0 &&
				key_w[0] == time_q) begin
				state_q   <= ST_REL;
				rel_cnt_q <= '0;
			end
			if (rel_fire) begin
				count_q   <= count_q - CNT_W'(1);
				rel_cnt_q <= rel_cnt_q + REL_W'(1);
				if (rel_last) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_rel_head_due: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REL |-> (count_q != '0) && (key_w[0] == time_q))
		else $error("release run with no due entry at the head");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the entry count");

	a_rel_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REL |-> !accept && !ctrl.insert)
		else $error("input taken during a release run");

endmodule

FILE: rtl/core/trq_cell.sv
module trq_cell (
	input  logic                                clk,
	input  trq_pkg::cell_ctrl_t                 ctrl,
	input  logic                                occ,
	input  logic [trq_pkg::TIME_W-1:0]          new_key,
	input  logic [trq_pkg::REF_W-1:0]           new_ref,
	input  logic                                left_gt,
	input  logic [trq_pkg::TIME_W-1:0]          left_key,
	input  logic [trq_pkg::REF_W-1:0]           left_ref,
	input  logic [trq_pkg::TIME_W-1:0]          right_key,
	input  logic [trq_pkg::REF_W-1:0]           right_ref,
	output logic                                gt,
	output logic [trq_pkg::TIME_W-1:0]          key,
	output logic [trq_pkg::REF_W-1:0]           ref_idx
);

	logic [trq_pkg::TIME_W-1:0] key_q;
	logic [trq_pkg::REF_W-1:0]  ref_q;

	// An empty cell counts as later than any new entry.
	assign gt      = !occ || (key_q > new_key);
	assign key     = key_q;
	assign ref_idx = ref_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && gt) begin
			key_q <= left_gt ? left_key : new_key;
			ref_q <= left_gt ? left_ref : new_ref;
		end else if (ctrl.shift) begin
			key_q <= right_key;
			ref_q <= right_ref;
		end
	end

endmodule

FILE: rtl/core/trq_rem.sv
module trq_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [trq_pkg::TIME_W-1:0]    dividend,
	input  logic [trq_pkg::QUANT_W-1:0]   divisor,
	output logic                          busy,
	output logic                          done,
	output logic [trq_pkg::QUANT_W-1:0]   remainder
);

	localparam int unsigned STEP_W = $clog2(trq_pkg::TIME_W);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [trq_pkg::TIME_W-1:0]    dvd_q;
	logic [trq_pkg::QUANT_W-1:0]   dvs_q;
	logic [trq_pkg::QUANT_W-1:0]   rem_q;
	logic [trq_pkg::QUANT_W:0]     trial;
	logic [trq_pkg::QUANT_W:0]     diff;

	assign trial = {rem_q, dvd_q[trq_pkg::TIME_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(trq_pkg::TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[trq_pkg::TIME_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[trq_pkg::QUANT_W-1:0];
			end else begin
				rem_q <= trial[trq_pkg::QUANT_W-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: tb/timed_release_queue_tb.sv
module timed_release_queue_tb;
	import trq_pkg::*;

	localparam int unsigned       DEPTH       = QUEUE_DEPTH_DEF;
	localparam logic [1:0]        MODE_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX    = '1;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [QUANT_W-1:0] cfg_wdata;

	trq_req_if req_ch ();
	trq_rsp_if rsp_ch ();

	timed_release_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [TIME_W-1:0]  sched_key [DEPTH];
	logic [REF_W-1:0]   sched_ref [DEPTH];
	int unsigned        sched_fill;
	logic [TIME_W-1:0]  sched_now;
	logic [QUANT_W-1:0] sched_quantum;
	trq_rsp_t           forecast_q [$];

	int unsigned errors;
	int unsigned rsp_seen;
	int unsigned n_adds, n_ticks, n_polls, n_unused;
	int unsigned n_released, n_full, n_missed, n_flags;
	bit          gap_en;
	bit          stall_en;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("%0t: run did not finish in time", $time);
		$display("TEST FAILED");
		$finish;
	end

	function automatic void push_outcome(input logic [2:0] kind, input logic [TIME_W-1:0] st,
			input logic [REF_W-1:0] ri, input logic qe, input logic last);
		trq_rsp_t r;
		r.kind            = kind;
		r.out_start_time  = st;
		r.out_ref_index   = ri;
		r.now             = sched_now;
		r.quantum_expired = qe;
		r.last            = last;
		forecast_q.push_back(r);
	endfunction

	task automatic forecast_op(input logic [1:0] op, input logic [TIME_W-1:0] st,
			input logic [REF_W-1:0] ri);
		int unsigned pos;
		int unsigned n;
		int unsigned k;
		logic        qe;
		case (op)
		MODE_ADD: begin
			n_adds++;
			if (sched_fill >= DEPTH) begin
				n_full++;
				push_outcome(KIND_FULL, '0, '0, 1'b0, 1'b1);
			end else begin
				pos = sched_fill;
				while (pos > 0 && sched_key[pos-1] > st) begin
					sched_key[pos] = sched_key[pos-1];
					sched_ref[pos] = sched_ref[pos-1];
					pos--;
				end
				sched_key[pos] = st;
				sched_ref[pos] = ri;
				sched_fill++;
				push_outcome(KIND_ADDED, '0, '0, 1'b0, 1'b1);
			end
		end
		MODE_TICK: begin
			n_ticks++;
			if (sched_now != TIME_MAX)
				sched_now++;
			qe = (sched_quantum != '0) && ((sched_now % sched_quantum) == 0);
			if (qe)
				n_flags++;
			push_outcome(KIND_TICKED, '0, '0, qe, 1'b1);
		end
		MODE_POLL: begin
			n_polls++;
			if (sched_fill == 0 || sched_key[0] > sched_now) begin
				push_outcome(KIND_NONE_DUE, '0, '0, 1'b0, 1'b1);
			end else if (sched_key[0] < sched_now) begin
				n_missed++;
				push_outcome(KIND_MISSED, '0, '0, 1'b0, 1'b1);
			end else begin
				n = 0;
				while (n < sched_fill && n < MAX_RESULTS && sched_key[n] == sched_now)
					n++;
				for (k = 0; k < n; k++)
					push_outcome(KIND_RELEASED, sched_key[k], sched_ref[k], 1'b0, k + 1 == n);
				for (k = 0; k + n < sched_fill; k++) begin
					sched_key[k] = sched_key[k+n];
					sched_ref[k] = sched_ref[k+n];
				end
				sched_fill -= n;
				n_released += n;
			end
		end
		default: begin
			n_unused++;
		end
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] st,
			input logic [REF_W-1:0] ri);
		if (gap_en && $urandom_range(0, 99) < 14) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= '{mode: op, start_time: st, ref_index: ri};
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		forecast_op(op, st, ri);
	endtask

	// Drops the request valid and waits until every forecast result has been checked.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (forecast_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_quantum(input logic [QUANT_W-1:0] q);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we        <= 1'b0;
		sched_quantum = q;
	endtask

	task automatic drain_queue();
		while (sched_fill != 0) begin
			if (sched_key[0] == sched_now)
				send_item(MODE_POLL, '0, '0);
			else
				send_item(MODE_TICK, '0, '0);
		end
	endtask

	task automatic test_empty_and_unused();
		send_item(MODE_POLL, '0, '0);
		send_item(MODE_UNUSED, TIME_MAX, '1);
		send_item(MODE_TICK, '0, '0);
	endtask

	// Later entries at the earlier time go to the head, behind equal keys already there.
	task automatic test_ordering_and_full();
		int unsigned       i;
		logic [TIME_W-1:0] st;
		logic [REF_W-1:0]  ri;
		for (i = 0; i < DEPTH; i++) begin
			st = (i % 4 == 1) ? sched_now + 1 : sched_now + 2;
			ri = (i == 0) ? '0 : (i == 1) ? '1 : REF_W'($urandom);
			send_item(MODE_ADD, st, ri);
		end
		send_item(MODE_ADD, sched_now, REF_W'($urandom));
		send_item(MODE_POLL, '0, '0);
		drain_queue();
	endtask

	task automatic test_quantum();
		set_quantum(16'd0);
		repeat (2) send_item(MODE_TICK, '0, '0);
		set_quantum(16'hFFFF);
		send_item(MODE_TICK, '0, '0);
		set_quantum(16'd3);
		repeat (3) send_item(MODE_TICK, '0, '0);
	endtask

	// Time only moves past the head once it has been released, so no start is ever missed here.
	task automatic random_traffic(input int unsigned count);
		int unsigned       done;
		int unsigned       r;
		logic [TIME_W-1:0] st;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				while (sched_fill < DEPTH) begin
					send_item(MODE_ADD, sched_now + 1, REF_W'($urandom));
					done++;
				end
			end else if (r < 44) begin
				st = (sched_fill < DEPTH) ? sched_now + $urandom_range(0, 3) : $urandom;
				send_item(MODE_ADD, st, REF_W'($urandom));
				done++;
			end else if (r < 70) begin
				if (sched_fill != 0 && sched_key[0] == sched_now)
					send_item(MODE_POLL, '0, '0);
				else
					send_item(MODE_TICK, $urandom, REF_W'($urandom));
				done++;
			end else if (r < 96) begin
				send_item(MODE_POLL, $urandom, REF_W'($urandom));
				done++;
			end else begin
				send_item(MODE_UNUSED, $urandom, REF_W'($urandom));
			end
		end
	endtask

	task automatic test_random_traffic();
		set_quantum(QUANT_W'($urandom_range(1, 6)));
		random_traffic(20);
		gap_en   = 1'b0;
		stall_en = 1'b0;
		random_traffic(20);
		gap_en   = 1'b1;
		stall_en = 1'b1;
		set_quantum(QUANT_W'($urandom_range(2, 9)));
		random_traffic(15);
	endtask

	// A head that is already late is never released, so this runs last.
	task automatic test_wide_fields_and_missed();
		drain_queue();
		send_item(MODE_ADD, TIME_MAX, '1);
		send_item(MODE_ADD, {1'b1, 31'($urandom)}, REF_W'($urandom));
		send_item(MODE_POLL, '0, '0);
		send_item(MODE_ADD, '0, '0);
		send_item(MODE_POLL, '0, '0);
		send_item(MODE_POLL, TIME_MAX, '1);
	endtask

	always @(posedge clk) begin : result_check
		trq_rsp_t want;
		trq_rsp_t got;
		bit       bad;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			rsp_seen++;
			if (forecast_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d", $time, got.kind);
			end else begin
				want = forecast_q.pop_front();
				bad  = 1'b0;
				if (got.kind !== want.kind) begin
					bad = 1'b1;
					$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
				end
				if (got.out_start_time !== want.out_start_time) begin
					bad = 1'b1;
					$display("%0t: out_start_time expected %0h actual %0h", $time,
						want.out_start_time, got.out_start_time);
				end
				if (got.out_ref_index !== want.out_ref_index) begin
					bad = 1'b1;
					$display("%0t: out_ref_index expected %0h actual %0h", $time,
						want.out_ref_index, got.out_ref_index);
				end
				if (got.now !== want.now) begin
					bad = 1'b1;
					$display("%0t: now expected %0d actual %0d", $time, want.now, got.now);
				end
				if (got.quantum_expired !== want.quantum_expired) begin
					bad = 1'b1;
					$display("%0t: quantum_expired expected %0b actual %0b", $time,
						want.quantum_expired, got.quantum_expired);
				end
				if (got.last !== want.last) begin
					bad = 1'b1;
					$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
				end
				if (bad)
					errors++;
			end
		end
		rsp_ch.ready <= (arst_n === 1'b1) && (!stall_en || $urandom_range(0, 99) >= 14);
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		errors       = 0;
		rsp_seen     = 0;
		n_adds       = 0;
		n_ticks      = 0;
		n_polls      = 0;
		n_unused     = 0;
		n_released   = 0;
		n_full       = 0;
		n_missed     = 0;
		n_flags      = 0;
		gap_en       = 1'b1;
		stall_en     = 1'b1;
		sched_fill    = 0;
		sched_now     = '0;
		sched_quantum = 16'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_unused();
		test_ordering_and_full();
		test_quantum();
		test_random_traffic();
		test_wide_fields_and_missed();

		settle();
		repeat (16) @(posedge clk);
		$display("Sent %0d adds, %0d ticks (%0d on a quantum boundary), %0d polls, %0d unused.",
			n_adds, n_ticks, n_flags, n_polls, n_unused);
		$display("Released %0d entries, %0d full rejections, %0d missed starts, %0d results checked.",
			n_released, n_full, n_missed, rsp_seen);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatching results.", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/trq_pkg.sv
rtl/core/trq_ifs.sv
rtl/core/trq_cell.sv
rtl/core/trq_rem.sv
rtl/core/timed_release_queue.sv
tb/timed_release_queue_tb.sv
